/* design/lca_bl_pkg.sv */
`default_nettype none

package lca_bl_pkg;

  localparam int NODES    = 1024;
  localparam int LEVELS   = 10;
  localparam int NODE_W   = 10;
  localparam int COUNT_W  = 11;
  localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int JT_DEPTH = NODES * LEVELS;
  localparam int JT_AW    = $clog2(JT_DEPTH);
  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = COUNT_W'(NODES);

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_B0_RD,
    S_B0_WR,
    S_BJ_RD1,
    S_BJ_RD2,
    S_BJ_WR,
    S_Q_DEP,
    S_Q_LIFT,
    S_Q_LIFTW,
    S_Q_CMP,
    S_Q_UP,
    S_Q_UPW,
    S_Q_LAST,
    S_Q_LASTW,
    S_FIN
  } state_e;

  // flat jump table address: level-major rows of NODES entries
  function automatic logic [JT_AW-1:0] jt_addr(input logic [LVL_W-1:0] lvl,
                                               input logic [NODE_W-1:0] node);
    jt_addr = JT_AW'(lvl) * JT_AW'(NODES) + JT_AW'(node);
  endfunction

endpackage

`default_nettype wire

/* design/lca_binary_lifting_engine.sv */
// Load and unused kinds: result registered at the transfer edge. Build: level 0 copies
//   each parent, then each higher entry takes one table read pair and a write.
// Query: depth compare, then a lift of the deeper node per set bit of the depth difference,
//   then, when the lifted nodes differ, a joint lift over every level and a parent read.
// One item in flight; a new item waits until the last result is taken. Async active-low
//   reset clears control state and sets node_count to 1024; stored tables are undefined until written.
`default_nettype none

module lca_binary_lifting_engine (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [1:0]                         kind_i,
  input  wire logic [lca_bl_pkg::NODE_W-1:0]      node_a_i,
  input  wire logic [lca_bl_pkg::NODE_W-1:0]      node_b_i,
  input  wire logic [lca_bl_pkg::NODE_W-1:0]      node_depth_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [lca_bl_pkg::NODE_W-1:0]           ancestor_o,
  output logic                                    is_answer_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [lca_bl_pkg::COUNT_W-1:0]     cfg_wdata_i
);

  localparam int NW = lca_bl_pkg::NODE_W;
  localparam int CW = lca_bl_pkg::COUNT_W;
  localparam int LW = lca_bl_pkg::LVL_W;
  localparam int AW = lca_bl_pkg::JT_AW;
  localparam logic [LW-1:0] LVL_TOP = LW'(lca_bl_pkg::LEVELS - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(lca_bl_pkg::NODES);

  // storage
  logic [NW-1:0] parent_mem [lca_bl_pkg::NODES];
  logic [NW-1:0] depth_mem  [lca_bl_pkg::NODES];
  logic [NW-1:0] jump_mem   [lca_bl_pkg::JT_DEPTH];

  logic          nd_we;
  logic [NW-1:0] nd_wa;
  logic [NW-1:0] par_ra, dep_ra, dep_rb;
  logic [NW-1:0] par_rd_q, dep_ra_q, dep_rb_q;

  logic          jt_we;
  logic [AW-1:0] jt_wa, jt_raa, jt_rab;
  logic [NW-1:0] jt_wd;
  logic [NW-1:0] jt_rda_q, jt_rdb_q;

  // control and datapath registers
  lca_bl_pkg::state_e state_q, state_d;
  logic [CW-1:0] node_count_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] lim_q, lim_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic [NW-1:0] a_q, a_d, b_q, b_d;
  logic [NW-1:0] diff_q, diff_d;
  logic [NW-1:0] res_q, res_d;
  logic          isq_q, isq_d;
  logic          out_valid_q, out_valid_d;
  logic [NW-1:0] ancestor_q, ancestor_d;
  logic          is_answer_q, is_answer_d;

  logic          out_free;
  logic          in_xfer;
  logic [CW-1:0] cnt_inc;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != lca_bl_pkg::S_IDLE) || !out_free;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cnt_inc     = cnt_q + CW'(1);
  assign out_valid_o = out_valid_q;
  assign ancestor_o  = ancestor_q;
  assign is_answer_o = is_answer_q;

  always_ff @(posedge clk_i) begin
    if (nd_we) begin
      parent_mem[nd_wa] <= node_b_i;
      depth_mem[nd_wa]  <= node_depth_i;
    end
    par_rd_q <= parent_mem[par_ra];
    dep_ra_q <= depth_mem[dep_ra];
    dep_rb_q <= depth_mem[dep_rb];
  end

  always_ff @(posedge clk_i) begin
    if (jt_we) begin
      jump_mem[jt_wa] <= jt_wd;
    end
    jt_rda_q <= jump_mem[jt_raa];
    jt_rdb_q <= jump_mem[jt_rab];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= lca_bl_pkg::NODE_COUNT_RST;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lca_bl_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    lim_q       <= lim_d;
    lvl_q       <= lvl_d;
    a_q         <= a_d;
    b_q         <= b_d;
    diff_q      <= diff_d;
    res_q       <= res_d;
    isq_q       <= isq_d;
    ancestor_q  <= ancestor_d;
    is_answer_q <= is_answer_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lim_d       = lim_q;
    lvl_d       = lvl_q;
    a_d         = a_q;
    b_d         = b_q;
    diff_d      = diff_q;
    res_d       = res_q;
    isq_d       = isq_q;
    ancestor_d  = ancestor_q;
    is_answer_d = is_answer_q;
    out_valid_d = out_valid_q && out_stall_i;

    nd_we  = 1'b0;
    nd_wa  = node_a_i;
    par_ra = cnt_q[NW-1:0];
    dep_ra = node_a_i;
    dep_rb = node_b_i;
    jt_we  = 1'b0;
    jt_wa  = lca_bl_pkg::jt_addr(lvl_q, cnt_q[NW-1:0]);
    jt_wd  = jt_rda_q;
    jt_raa = lca_bl_pkg::jt_addr(lvl_q, a_q);
    jt_rab = lca_bl_pkg::jt_addr(lvl_q, b_q);

    unique case (state_q)
      lca_bl_pkg::S_IDLE: begin
        if (in_xfer) begin
          a_d   = node_a_i;
          b_d   = node_b_i;
          cnt_d = '0;
          lvl_d = '0;
          res_d = '0;
          isq_d = 1'b0;
          unique case (kind_i)
            lca_bl_pkg::KIND_LOAD: begin
              nd_we       = 1'b1;
              out_valid_d = 1'b1;
              ancestor_d  = '0;
              is_answer_d = 1'b0;
            end
            lca_bl_pkg::KIND_BUILD: begin
              lim_d   = (node_count_q > CNT_MAX) ? CNT_MAX : node_count_q;
              state_d = (node_count_q == '0) ? lca_bl_pkg::S_FIN : lca_bl_pkg::S_B0_RD;
            end
            lca_bl_pkg::KIND_QUERY: begin
              isq_d   = 1'b1;
              state_d = lca_bl_pkg::S_Q_DEP;
            end
            lca_bl_pkg::KIND_NONE: begin
              out_valid_d = 1'b1;
              ancestor_d  = '0;
              is_answer_d = 1'b0;
            end
          endcase
        end
      end

      // level 0 is the stored parent
      lca_bl_pkg::S_B0_RD: begin
        state_d = lca_bl_pkg::S_B0_WR;
      end
      lca_bl_pkg::S_B0_WR: begin
        jt_we = 1'b1;
        jt_wd = par_rd_q;
        cnt_d = cnt_inc;
        if (cnt_inc == lim_q) begin
          cnt_d = '0;
          if (lvl_q == LVL_TOP) begin
            state_d = lca_bl_pkg::S_FIN;
          end else begin
            lvl_d   = lvl_q + LW'(1);
            state_d = lca_bl_pkg::S_BJ_RD1;
          end
        end else begin
          state_d = lca_bl_pkg::S_B0_RD;
        end
      end

      // entry(v, j) = entry(entry(v, j-1), j-1)
      lca_bl_pkg::S_BJ_RD1: begin
        jt_raa  = lca_bl_pkg::jt_addr(lvl_q - LW'(1), cnt_q[NW-1:0]);
        state_d = lca_bl_pkg::S_BJ_RD2;
      end
      lca_bl_pkg::S_BJ_RD2: begin
        jt_raa  = lca_bl_pkg::jt_addr(lvl_q - LW'(1), jt_rda_q);
        state_d = lca_bl_pkg::S_BJ_WR;
      end
      lca_bl_pkg::S_BJ_WR: begin
        jt_we = 1'b1;
        cnt_d = cnt_inc;
        if (cnt_inc == lim_q) begin
          cnt_d = '0;
          if (lvl_q == LVL_TOP) begin
            state_d = lca_bl_pkg::S_FIN;
          end else begin
            lvl_d   = lvl_q + LW'(1);
            state_d = lca_bl_pkg::S_BJ_RD1;
          end
        end else begin
          state_d = lca_bl_pkg::S_BJ_RD1;
        end
      end

      // make a the deeper node
      lca_bl_pkg::S_Q_DEP: begin
        if (dep_ra_q < dep_rb_q) begin
          a_d    = b_q;
          b_d    = a_q;
          diff_d = dep_rb_q - dep_ra_q;
        end else begin
          diff_d = dep_ra_q - dep_rb_q;
        end
        lvl_d   = LVL_TOP;
        state_d = lca_bl_pkg::S_Q_LIFT;
      end
      lca_bl_pkg::S_Q_LIFT: begin
        if (diff_q[lvl_q]) begin
          state_d = lca_bl_pkg::S_Q_LIFTW;
        end else if (lvl_q == '0) begin
          state_d = lca_bl_pkg::S_Q_CMP;
        end else begin
          lvl_d = lvl_q - LW'(1);
        end
      end
      lca_bl_pkg::S_Q_LIFTW: begin
        a_d = jt_rda_q;
        if (lvl_q == '0) begin
          state_d = lca_bl_pkg::S_Q_CMP;
        end else begin
          lvl_d   = lvl_q - LW'(1);
          state_d = lca_bl_pkg::S_Q_LIFT;
        end
      end
      lca_bl_pkg::S_Q_CMP: begin
        if (a_q == b_q) begin
          res_d   = a_q;
          state_d = lca_bl_pkg::S_FIN;
        end else begin
          lvl_d   = LVL_TOP;
          state_d = lca_bl_pkg::S_Q_UP;
        end
      end
      lca_bl_pkg::S_Q_UP: begin
        state_d = lca_bl_pkg::S_Q_UPW;
      end
      lca_bl_pkg::S_Q_UPW: begin
        if (jt_rda_q != jt_rdb_q) begin
          a_d = jt_rda_q;
          b_d = jt_rdb_q;
        end
        if (lvl_q == '0) begin
          state_d = lca_bl_pkg::S_Q_LAST;
        end else begin
          lvl_d   = lvl_q - LW'(1);
          state_d = lca_bl_pkg::S_Q_UP;
        end
      end
      lca_bl_pkg::S_Q_LAST: begin
        jt_raa  = lca_bl_pkg::jt_addr('0, a_q);
        state_d = lca_bl_pkg::S_Q_LASTW;
      end
      lca_bl_pkg::S_Q_LASTW: begin
        res_d   = jt_rda_q;
        state_d = lca_bl_pkg::S_FIN;
      end

      lca_bl_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ancestor_d  = res_q;
          is_answer_d = isq_q;
          state_d     = lca_bl_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = lca_bl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* dv/lca_binary_lifting_engine_tb.sv */
`timescale 1ns / 1ps

module lca_binary_lifting_engine_tb;

  localparam int NODE_W  = lca_bl_pkg::NODE_W;
  localparam int COUNT_W = lca_bl_pkg::COUNT_W;
  localparam int NODES   = lca_bl_pkg::NODES;
  localparam int LEVELS  = lca_bl_pkg::LEVELS;

  localparam lca_bl_pkg::kind_e KIND_LOAD  = lca_bl_pkg::KIND_LOAD;
  localparam lca_bl_pkg::kind_e KIND_BUILD = lca_bl_pkg::KIND_BUILD;
  localparam lca_bl_pkg::kind_e KIND_QUERY = lca_bl_pkg::KIND_QUERY;
  localparam lca_bl_pkg::kind_e KIND_NONE  = lca_bl_pkg::KIND_NONE;

  localparam int QUIET_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT     = 300;
  localparam int MAX_PRINTS  = 40;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic              is_answer;
  } result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_e;

  typedef struct packed {
    row_e                 op;
    lca_bl_pkg::kind_e    kind;
    logic [NODE_W-1:0]    a;
    logic [NODE_W-1:0]    b;
    logic [NODE_W-1:0]    d;
    logic [COUNT_W-1:0]   cfg;
    logic                 typed;
    logic [NODE_W-1:0]    want_anc;
    logic                 want_ans;
  } dir_row_t;

  // typed rows carry their result; query rows go through the predictor
  localparam int DIR_N = 24;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{ROW_ITEM, KIND_NONE,  10'd0,    10'd0,    10'd0,    11'd0, 1'b1, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_NONE,  10'd1023, 10'd1023, 10'd1023, 11'd0, 1'b1, 10'd0, 1'b0},
    '{ROW_CFG,  KIND_NONE,  10'd0,    10'd0,    10'd0,    11'd0, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_BUILD, 10'd0,    10'd0,    10'd0,    11'd0, 1'b1, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_LOAD,  10'd1023, 10'd1023, 10'd1023, 11'd0, 1'b1, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_LOAD,  10'd0,    10'd0,    10'd0,    11'd0, 1'b1, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_LOAD,  10'd1,    10'd0,    10'd1,    11'd0, 1'b1, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_LOAD,  10'd2,    10'd0,    10'd1,    11'd0, 1'b1, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_LOAD,  10'd3,    10'd1,    10'd2,    11'd0, 1'b1, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_LOAD,  10'd4,    10'd1,    10'd2,    11'd0, 1'b1, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_LOAD,  10'd5,    10'd3,    10'd3,    11'd0, 1'b1, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_LOAD,  10'd6,    10'd2,    10'd2,    11'd0, 1'b1, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_LOAD,  10'd7,    10'd6,    10'd3,    11'd0, 1'b1, 10'd0, 1'b0},
    '{ROW_CFG,  KIND_NONE,  10'd0,    10'd0,    10'd0,    11'd8, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_BUILD, 10'd0,    10'd0,    10'd0,    11'd0, 1'b1, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_QUERY, 10'd5,    10'd4,    10'd0,    11'd0, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_QUERY, 10'd7,    10'd5,    10'd0,    11'd0, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_QUERY, 10'd5,    10'd5,    10'd0,    11'd0, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_QUERY, 10'd0,    10'd7,    10'd0,    11'd0, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_QUERY, 10'd3,    10'd5,    10'd0,    11'd0, 1'b0, 10'd0, 1'b0},
    // reload after build: depth changes, table does not
    '{ROW_ITEM, KIND_LOAD,  10'd4,    10'd0,    10'd1,    11'd0, 1'b1, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_QUERY, 10'd4,    10'd3,    10'd0,    11'd0, 1'b0, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_LOAD,  10'd6,    10'd6,    10'd7,    11'd0, 1'b1, 10'd0, 1'b0},
    '{ROW_ITEM, KIND_QUERY, 10'd7,    10'd0,    10'd0,    11'd0, 1'b0, 10'd0, 1'b0}
  };

  localparam int PHASES = 12;
  localparam int PHASE_COUNTS [PHASES] = '{1, 2, 5, 17, 33, 64, 2047, 1024, 40, 3, 0, 25};

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic [1:0] kind_d;
  logic [NODE_W-1:0] node_a_d;
  logic [NODE_W-1:0] node_b_d;
  logic [NODE_W-1:0] depth_d;
  logic out_stall;
  logic cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;
  logic in_stall_o;
  logic out_valid_o;
  logic [NODE_W-1:0] ancestor_o;
  logic is_answer_o;

  // predictor state
  logic [NODE_W-1:0]  parent_mem [NODES];
  logic [NODE_W-1:0]  depth_mem  [NODES];
  logic [NODE_W-1:0]  lift_tab   [LEVELS][NODES];
  logic [COUNT_W-1:0] node_count_q = lca_bl_pkg::NODE_COUNT_RST;

  // stimulus bookkeeping
  bit loaded [NODES];
  int built_limit = 0;
  bit calm = 1'b0;
  result_t answer_q [$];

  int errors = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit held = 1'b0;
  int quiet_cycles = 0;
  int n_loads = 0;
  int n_builds = 0;
  int n_queries = 0;
  int n_unused = 0;
  int n_cfg = 0;

  lca_binary_lifting_engine u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_d),
    .node_a_i     (node_a_d),
    .node_b_i     (node_b_d),
    .node_depth_i (depth_d),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .ancestor_o   (ancestor_o),
    .is_answer_o  (is_answer_o),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [NODE_W-1:0] rnd_node();
    return NODE_W'($urandom_range(NODES - 1, 0));
  endfunction

  function automatic result_t step_tree(input lca_bl_pkg::kind_e kind,
                                        input logic [NODE_W-1:0] a,
                                        input logic [NODE_W-1:0] b,
                                        input logic [NODE_W-1:0] d);
    result_t r;
    int cnt;
    logic [NODE_W-1:0] x, y, t, jx, jy, diff;
    r = '0;
    case (kind)
      KIND_LOAD: begin
        parent_mem[a] = b;
        depth_mem[a]  = d;
      end
      KIND_BUILD: begin
        cnt = (node_count_q > COUNT_W'(NODES)) ? NODES : int'(node_count_q);
        for (int v = 0; v < cnt; v++) lift_tab[0][v] = parent_mem[v];
        for (int j = 1; j < LEVELS; j++)
          for (int v = 0; v < cnt; v++) lift_tab[j][v] = lift_tab[j-1][lift_tab[j-1][v]];
      end
      KIND_QUERY: begin
        x = a;
        y = b;
        if (depth_mem[x] < depth_mem[y]) begin
          t = x;
          x = y;
          y = t;
        end
        diff = depth_mem[x] - depth_mem[y];
        for (int i = LEVELS - 1; i >= 0; i--)
          if (diff[i]) x = lift_tab[i][x];
        if (x != y) begin
          for (int i = LEVELS - 1; i >= 0; i--) begin
            jx = lift_tab[i][x];
            jy = lift_tab[i][y];
            if (jx != jy) begin
              x = jx;
              y = jy;
            end
          end
          x = lift_tab[0][x];
        end
        r.ancestor  = x;
        r.is_answer = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  // valid stays high after a transfer; the next call or the caller lowers it
  task automatic send_item(input lca_bl_pkg::kind_e kind, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b, input logic [NODE_W-1:0] d,
                           input bit typed, input result_t typed_res);
    result_t predicted;
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind_d   <= kind;
    node_a_d <= a;
    node_b_d <= b;
    depth_d  <= d;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = step_tree(kind, a, b, d);
    if (typed) predicted = typed_res;
    answer_q.insert(answer_q.size(), predicted);
    case (kind)
      KIND_LOAD: begin
        loaded[a] = 1'b1;
        n_loads++;
      end
      KIND_BUILD: begin
        n_builds++;
        if (int'(node_count_q) > built_limit)
          built_limit = (node_count_q > COUNT_W'(NODES)) ? NODES : int'(node_count_q);
      end
      KIND_QUERY: n_queries++;
      default: n_unused++;
    endcase
  endtask

  task automatic write_node_count(input logic [COUNT_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    node_count_q = v;
    n_cfg++;
  endtask

  // parent never above the node index, so every ancestor of a built node is built
  task automatic load_node(input int v);
    logic [NODE_W-1:0] p, dep;
    if (v == 0 || $urandom_range(0, 9) == 0) p = NODE_W'(v);
    else if ($urandom_range(0, 9) < 6)
      p = NODE_W'($urandom_range(v - 1, (v > 4) ? v - 4 : 0));
    else p = NODE_W'($urandom_range(v - 1, 0));
    dep = (p == v) ? '0 : depth_mem[p] + 1'b1;
    if ($urandom_range(0, 9) == 0) dep = rnd_node();
    send_item(KIND_LOAD, NODE_W'(v), p, dep, 1'b0, '0);
  endtask

  initial begin
    int eff, ops, sel, lim, steps;
    logic [NODE_W-1:0] qa, qb, tmp;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    kind_d    = '0;
    node_a_d  = '0;
    node_b_d  = '0;
    depth_d   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    for (int i = 0; i < NODES; i++) begin
      parent_mem[i] = '0;
      depth_mem[i]  = '0;
      loaded[i]     = 1'b0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_N; r++) begin
      if (DIR_ROWS[r].op == ROW_CFG) write_node_count(DIR_ROWS[r].cfg);
      else send_item(DIR_ROWS[r].kind, DIR_ROWS[r].a, DIR_ROWS[r].b, DIR_ROWS[r].d,
                     DIR_ROWS[r].typed,
                     result_t'{DIR_ROWS[r].want_anc, DIR_ROWS[r].want_ans});
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph == 3 || ph == 4);
      write_node_count(COUNT_W'(PHASE_COUNTS[ph]));
      eff = (PHASE_COUNTS[ph] > NODES) ? NODES : PHASE_COUNTS[ph];
      for (int v = 0; v < eff; v++)
        if (!loaded[v]) load_node(v);
      send_item(KIND_BUILD, rnd_node(), rnd_node(), rnd_node(), 1'b0, '0);
      ops = (eff >= NODES) ? 30 : 6;
      repeat (ops) begin
        lim = built_limit;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          qa = NODE_W'($urandom_range(lim - 1, 0));
          case ($urandom_range(0, 3))
            0: qb = NODE_W'($urandom_range(lim - 1, 0));
            1: qb = qa;
            2: begin
              qb = qa;
              steps = $urandom_range(1, 6);
              repeat (steps) qb = parent_mem[qb];
            end
            default: qb = NODE_W'($urandom_range(qa, (qa > 8) ? qa - 8 : 0));
          endcase
          if ($urandom_range(0, 1)) begin
            tmp = qa;
            qa  = qb;
            qb  = tmp;
          end
          send_item(KIND_QUERY, qa, qb, rnd_node(), 1'b0, '0);
        end else if (sel < 82) begin
          if ($urandom_range(0, 9) < 7)
            load_node($urandom_range((lim + 8 > NODES - 1) ? NODES - 1 : lim + 8, 0));
          else
            load_node($urandom_range(NODES - 1, 0));
        end else if (sel < 90) begin
          send_item(KIND_BUILD, rnd_node(), rnd_node(), rnd_node(), 1'b0, '0);
        end else if (sel < 95) begin
          send_item(KIND_NONE, rnd_node(), rnd_node(), rnd_node(), 1'b0, '0);
        end else begin
          // the highest-numbered nodes sit at the bottom of the longest chains
          qa = NODE_W'($urandom_range(lim - 1, (lim > 16) ? lim - 16 : 0));
          qb = NODE_W'($urandom_range(lim - 1, (lim > 16) ? lim - 16 : 0));
          send_item(KIND_QUERY, qa, qb, rnd_node(), 1'b0, '0);
        end
      end
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d loads, %0d builds, %0d queries, %0d unused-kind transfers",
             n_loads, n_builds, n_queries, n_unused);
    $display("node_count written %0d times, %0d results checked, %0d mismatches",
             n_cfg, results_seen, errors);
    if (errors == 0) begin
      $display("[lca_binary_lifting_engine] OK");
    end else begin
      $display("[lca_binary_lifting_engine] ERROR");
    end
    $finish;
  end

  // result side: check, random stall, one long hold-off
  initial begin
    result_t want;
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && !out_stall) begin
        results_seen++;
        if (answer_q.size() == 0) begin
          report_mismatch($sformatf("nothing pending, got ancestor %0d answer %0b",
                                    ancestor_o, is_answer_o));
        end else begin
          want = answer_q.pop_front();
          if (ancestor_o !== want.ancestor)
            report_mismatch($sformatf("ancestor %0d, want %0d", ancestor_o, want.ancestor));
          if (is_answer_o !== want.is_answer)
            report_mismatch($sformatf("is_answer %0b, want %0b", is_answer_o, want.is_answer));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held && results_seen >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 32);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results pending", quiet_cycles,
               answer_q.size());
      $display("[lca_binary_lifting_engine] ERROR");
      $finish;
    end
  end

endmodule

/* files.f */
design/lca_bl_pkg.sv
design/lca_binary_lifting_engine.sv
dv/lca_binary_lifting_engine_tb.sv
